// ----- rtl/bfra_pkg.sv -----
// Package for the best-fit region allocator: payload structs, codes, widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfra_pkg;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned SIZE_W = 21;
    localparam int unsigned ADDR_W = 20;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned ST_W   = 3;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_COMPACT = 2'd2,
        REQ_STATUS  = 2'd3
    } t_req_type;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_FIT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_ID    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_SIZE = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ID_W-1:0]   owner_id;
        logic [SIZE_W-1:0] req_size;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] region_start;
        logic [SIZE_W-1:0] used_sum;
        logic [SIZE_W-1:0] free_sum;
        logic [CNT_W-1:0]  holes_in_use;
        logic [CNT_W-1:0]  allocs_in_use;
    } t_out;

    // One table entry (hole or allocation); a hole uses owner zero.
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [ADDR_W:0]   start;
        logic [SIZE_W:0]   size;
    } t_ent;

endpackage
`default_nettype wire

// ----- rtl/bfra_cell.sv -----
// One slot of a sorted table held as a chain of cells.
// Depends on bfra_pkg. Each cycle a cell loads its own value, its right
// neighbor's (shift down), its left neighbor's (shift up) or an explicit value.
`timescale 1ns / 1ps
`default_nettype none
module bfra_cell (
    input  wire                   i_clk,
    input  wire             [1:0] i_op,
    input  bfra_pkg::t_ent        i_left,
    input  bfra_pkg::t_ent        i_right,
    input  bfra_pkg::t_ent        i_wdata,
    input  wire                   i_we,
    output bfra_pkg::t_ent        o_q
);
    import bfra_pkg::*;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_DOWN = 2'd1;
    localparam logic [1:0] OP_UP   = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    t_ent r_q;
    t_ent n_q;

    // Pick next slot value
    always_comb begin
        unique case (i_op)
            OP_HOLD: n_q = r_q;
            OP_DOWN: n_q = i_right;
            OP_UP:   n_q = i_left;
            default: n_q = i_wdata;
        endcase
        if (i_we) begin
            n_q = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ----- rtl/bfra_chain.sv -----
// Row of bfra_cell slots with per-slot shift control and one direct write.
// Depends on bfra_pkg and bfra_cell. Slot 0 is the head of the table.
`timescale 1ns / 1ps
`default_nettype none
module bfra_chain #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire        [DEPTH-1:0]       i_shift_dn,
    input  wire        [DEPTH-1:0]       i_shift_up,
    input  wire        [DEPTH-1:0]       i_we,
    input  bfra_pkg::t_ent               i_wdata,
    output bfra_pkg::t_ent [DEPTH-1:0]   o_q
);
    import bfra_pkg::*;

    t_ent [DEPTH-1:0] w_q;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_ent w_l;
        t_ent w_r;
        if (g == 0) begin : g_h
            assign w_l = '0;
        end else begin : g_m
            assign w_l = w_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_t
            assign w_r = '0;
        end else begin : g_n
            assign w_r = w_q[g+1];
        end
        bfra_cell u_cell (
            .i_clk   (i_clk),
            .i_op    ({i_shift_up[g], i_shift_dn[g]}),
            .i_left  (w_l),
            .i_right (w_r),
            .i_wdata (i_wdata),
            .i_we    (i_we[g]),
            .o_q     (w_q[g])
        );
    end

    assign o_q = w_q;
endmodule
`default_nettype wire

// ----- rtl/best_fit_region_allocator.sv -----
// Top level of the best-fit region allocator: control sequencer plus two
// chains of cells (hole table sorted by start, allocation table in grant order).
// Depends on bfra_pkg, bfra_chain, bfra_cell.
//
//  channel | direction | signals
//  in      | input     | i_in_valid, o_in_ready, i_in (t_in)
//  out     | output    | o_out_valid, i_out_ready, o_out (t_out)
//
// One transaction at a time; steps from acceptance to the result register:
//   request: hole scan, totals walk
//   release: owner scan, allocation shift, hole search, hole merge or insert,
//            a second hole shift when both neighbors merge, totals walk
//   compact: allocation walk, totals walk; status: totals walk
// The walks go one slot per cycle over the chains. Reset rebuilds the single top
// hole. A finished transaction waits until the previous result is taken;
// the result register holds under stall and input ready stays low until then.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_region_allocator #(
    parameter int unsigned MEM_SIZE    = 1048576,
    parameter int unsigned ALLOC_DEPTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  bfra_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bfra_pkg::t_out      o_out
);
    import bfra_pkg::*;

    localparam int unsigned HOLES = ALLOC_DEPTH + 1;
    localparam int unsigned IW    = $clog2(HOLES + 1);
    localparam int unsigned CW    = $clog2(ALLOC_DEPTH + 2);
    localparam int unsigned MW    = $clog2(MEM_SIZE) + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_FIT, S_AFIND, S_ASHIFT, S_HFIND, S_HEDIT, S_HSHIFT,
        S_CMP, S_SUM, S_DONE
    } t_state;

    t_state          r_state;
    t_in             r_req;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_best;
    logic [ADDR_W:0] r_bst;
    logic [MW-1:0]   r_bsz;
    logic            r_found;
    logic [CW-1:0]   r_htot;
    logic [CW-1:0]   r_atot;
    logic [MW-1:0]   r_s;
    logic [MW-1:0]   r_z;
    logic [MW-1:0]   r_ta;
    logic [MW-1:0]   r_tf;
    logic [ST_W-1:0] r_st;
    logic            r_left;
    t_out            r_out;

    t_ent [HOLES-1:0]       w_h;
    t_ent [ALLOC_DEPTH-1:0] w_a;
    logic [HOLES-1:0]       h_dn, h_up, h_we;
    logic [ALLOC_DEPTH-1:0] a_dn, a_up, a_we;
    t_ent                   h_wd, a_wd;

    bfra_chain #(.DEPTH(HOLES)) u_holes (
        .i_clk(i_clk), .i_shift_dn(h_dn), .i_shift_up(h_up), .i_we(h_we),
        .i_wdata(h_wd), .o_q(w_h)
    );
    bfra_chain #(.DEPTH(ALLOC_DEPTH)) u_allocs (
        .i_clk(i_clk), .i_shift_dn(a_dn), .i_shift_up(a_up), .i_we(a_we),
        .i_wdata(a_wd), .o_q(w_a)
    );

    // Entries under scan
    t_ent        w_hc, w_ac, w_hp;
    logic [MW-1:0] w_hsz, w_hst;
    always_comb begin
        w_hc = w_h[r_idx[$clog2(HOLES)-1:0]];
        w_hp = w_h[r_idx[$clog2(HOLES)-1:0] - 1'b1];
        w_ac = w_a[r_idx[$clog2(ALLOC_DEPTH)-1:0]];
        w_hsz = MW'(w_hc.size);
        w_hst = MW'(w_hc.start);
    end

    // Chain control
    always_comb begin
        h_dn = '0; h_up = '0; h_we = '0; h_wd = '0;
        a_dn = '0; a_up = '0; a_we = '0; a_wd = '0;
        if (!i_rst_n) begin
            h_we[0]    = 1'b1;
            h_wd.start = '0;
            h_wd.size  = (SIZE_W+1)'(MEM_SIZE);
        end else begin
            unique case (r_state)
                S_FIT: begin
                    if (r_idx == IW'(r_htot) && r_found &&
                        r_bsz == MW'(r_req.req_size)) begin
                        // hole used up: drop it
                        for (int k = 0; k < HOLES; k++)
                            h_dn[k] = (IW'(k) >= r_best);
                    end else if (r_idx == IW'(r_htot) && r_found) begin
                        h_we[r_best[$clog2(HOLES)-1:0]] = 1'b1;
                        h_wd.start = (ADDR_W+1)'(MW'(r_bst) + MW'(r_req.req_size));
                        h_wd.size  = (SIZE_W+1)'(r_bsz - MW'(r_req.req_size));
                    end
                    if (r_idx == IW'(r_htot) && r_found) begin
                        a_we[r_atot[$clog2(ALLOC_DEPTH)-1:0]] = 1'b1;
                        a_wd.owner = r_req.owner_id;
                        a_wd.start = r_bst;
                        a_wd.size  = (SIZE_W+1)'(r_req.req_size);
                    end
                end
                S_ASHIFT: begin
                    for (int k = 0; k < ALLOC_DEPTH; k++)
                        a_dn[k] = (IW'(k) >= r_idx);
                end
                S_HEDIT: begin
                    if (r_left) begin
                        h_we[r_idx[$clog2(HOLES)-1:0] - 1'b1] = 1'b1;
                        h_wd.start = w_hp.start;
                        h_wd.size  = (SIZE_W+1)'(MW'(w_hp.size) + r_z +
                                     ((r_idx < IW'(r_htot) && r_s + r_z == w_hst)
                                      ? w_hsz : '0));
                    end else if (r_idx < IW'(r_htot) && r_s + r_z == w_hst) begin
                        h_we[r_idx[$clog2(HOLES)-1:0]] = 1'b1;
                        h_wd.start = (ADDR_W+1)'(r_s);
                        h_wd.size  = (SIZE_W+1)'(w_hsz + r_z);
                    end else if (r_htot < CW'(HOLES)) begin
                        for (int k = 0; k < HOLES; k++)
                            h_up[k] = (IW'(k) > r_idx);
                        h_we[r_idx[$clog2(HOLES)-1:0]] = 1'b1;
                        h_wd.start = (ADDR_W+1)'(r_s);
                        h_wd.size  = (SIZE_W+1)'(r_z);
                    end
                end
                S_HSHIFT: begin
                    for (int k = 0; k < HOLES; k++)
                        h_dn[k] = (IW'(k) >= r_idx);
                end
                S_CMP: begin
                    if (r_idx < IW'(r_atot)) begin
                        a_we[r_idx[$clog2(ALLOC_DEPTH)-1:0]] = 1'b1;
                        a_wd = w_ac;
                        a_wd.start = (ADDR_W+1)'(r_ta);
                    end else if (r_ta < MW'(MEM_SIZE)) begin
                        h_we[0] = 1'b1;
                        h_wd.start = (ADDR_W+1)'(r_ta);
                        h_wd.size  = (SIZE_W+1)'(MW'(MEM_SIZE) - r_ta);
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_htot      <= CW'(1);
            r_atot      <= '0;
            o_in_ready  <= 1'b1;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        o_in_ready <= 1'b0;
                        r_req   <= i_in;
                        r_idx   <= '0;
                        r_best  <= '0;
                        r_found <= 1'b0;
                        r_st    <= ST_OK;
                        r_s     <= '0;
                        r_ta    <= '0;
                        r_tf    <= '0;
                        unique case (t_req_type'(i_in.req_type))
                            REQ_ALLOC: begin
                                if (i_in.req_size == '0) begin
                                    r_st <= ST_BAD_SIZE; r_state <= S_SUM;
                                end else if (r_atot >= CW'(ALLOC_DEPTH)) begin
                                    r_st <= ST_FULL; r_state <= S_SUM;
                                end else begin
                                    r_state <= S_FIT;
                                end
                            end
                            REQ_RELEASE: r_state <= S_AFIND;
                            REQ_COMPACT: r_state <= S_CMP;
                            default:     r_state <= S_SUM;
                        endcase
                    end
                end
                S_FIT: begin
                    if (r_idx < IW'(r_htot)) begin
                        if (w_hsz >= MW'(r_req.req_size) &&
                            (!r_found || w_hsz < r_bsz)) begin
                            r_best  <= r_idx;
                            r_bst   <= w_hc.start;
                            r_bsz   <= w_hsz;
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx <= '0;
                        r_state <= S_SUM;
                        if (!r_found) begin
                            r_st <= ST_NO_FIT;
                        end else begin
                            r_s <= MW'(r_bst);
                            r_atot <= r_atot + 1'b1;
                            if (r_bsz == MW'(r_req.req_size))
                                r_htot <= r_htot - 1'b1;
                        end
                    end
                end
                S_AFIND: begin
                    if (r_idx >= IW'(r_atot)) begin
                        r_st <= ST_NO_ID; r_idx <= '0; r_state <= S_SUM;
                    end else if (w_ac.owner == r_req.owner_id) begin
                        r_s <= MW'(w_ac.start);
                        r_z <= MW'(w_ac.size);
                        r_state <= S_ASHIFT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ASHIFT: begin
                    r_atot <= r_atot - 1'b1;
                    r_idx <= '0;
                    r_state <= S_HFIND;
                end
                S_HFIND: begin
                    if (r_idx < IW'(r_htot) && w_hst < r_s) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_left <= (r_idx != '0) &&
                                  (MW'(w_hp.start) + MW'(w_hp.size) == r_s);
                        r_state <= S_HEDIT;
                    end
                end
                S_HEDIT: begin
                    if (r_left && r_idx < IW'(r_htot) && r_s + r_z == w_hst) begin
                        r_state <= S_HSHIFT;
                    end else begin
                        if (!r_left && !(r_idx < IW'(r_htot) && r_s + r_z == w_hst)
                            && r_htot < CW'(HOLES))
                            r_htot <= r_htot + 1'b1;
                        r_idx <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_HSHIFT: begin
                    r_htot <= r_htot - 1'b1;
                    r_idx <= '0;
                    r_state <= S_SUM;
                end
                S_CMP: begin
                    if (r_idx < IW'(r_atot)) begin
                        r_ta  <= r_ta + MW'(w_ac.size);
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_htot <= (r_ta < MW'(MEM_SIZE)) ? CW'(1) : '0;
                        r_ta  <= '0;
                        r_idx <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // accumulate both tables in one walk
                    if (r_idx < IW'(r_atot))
                        r_ta <= r_ta + MW'(w_ac.size);
                    if (r_idx < IW'(r_htot))
                        r_tf <= r_tf + w_hsz;
                    if (r_idx >= IW'(r_atot) && r_idx >= IW'(r_htot)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid) begin
                        r_out.status          <= r_st;
                        r_out.region_start    <= (r_st == ST_OK &&
                            (r_req.req_type == REQ_ALLOC || r_req.req_type == REQ_RELEASE))
                            ? ADDR_W'(r_s) : '0;
                        r_out.used_sum        <= SIZE_W'(r_ta);
                        r_out.free_sum        <= SIZE_W'(r_tf);
                        r_out.holes_in_use    <= CNT_W'(r_htot);
                        r_out.allocs_in_use   <= CNT_W'(r_atot);
                        o_out_valid <= 1'b1;
                        o_in_ready  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Drop the result once it is taken
            if (o_out_valid && i_out_ready)
                o_out_valid <= 1'b0;
        end
    end

    assign o_out = r_out;
endmodule
`default_nettype wire
